>>> rtl/pda_pkg.sv
`default_nettype none
package pda_pkg;

  localparam int unsigned GRID_DEFAULT = 4;
  localparam logic [31:0] BOX_RESET    = 32'd6553600;
  // floor(x / 10) for any 32-bit x as (x * HALO_RECIP) >> HALO_SHIFT
  localparam logic [31:0] HALO_RECIP   = 32'hCCCC_CCCD;
  localparam int unsigned HALO_SHIFT   = 35;
  localparam int unsigned MAX_REC      = 8;

  typedef enum logic [2:0] {F_CELL, F_OV, F_IDLE, F_HOME, F_PUSH} front_state_t;
  typedef enum logic [0:0] {B_RUN, B_DONE} back_state_t;

  typedef struct packed {
    logic [31:0] box;
    logic [31:0] dom_size;
    logic [31:0] ov;
  } geom_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [2:0]  hx;
    logic [2:0]  hy;
    logic [2:0]  hz;
    logic [30:0] part;
    logic [9:0]  file;
  } task_t;

  typedef struct packed {
    logic [5:0]  domain_index;
    logic        matched;
    logic        interior;
    logic [31:0] record_number;
    logic [30:0] echo_particle;
    logic [9:0]  echo_file;
    logic        last;
  } rec_t;

  // point within the widened bounds, moved by one box toward the centre if far
  function automatic logic axis_holds(input logic [31:0] p, input logic [31:0] lvl,
                                      input logic [31:0] csize, input logic [31:0] ov,
                                      input logic [31:0] box);
    logic signed [37:0] sp, sl, sc, so, sb, c2, d, q;
    begin
      sp = signed'({6'd0, p});
      sl = signed'({6'd0, lvl});
      sc = signed'({6'd0, csize});
      so = signed'({6'd0, ov});
      sb = signed'({6'd0, box});
      c2 = sl + sl + sc;
      d  = sp + sp - c2;
      q  = sp;
      if (d > sb || -d > sb) begin
        q = (c2 > sp + sp) ? sp + sb : sp - sb;
      end
      return (q >= sl - so) && (q <= sl + sc + so);
    end
  endfunction

  function automatic logic axis_core(input logic [31:0] p, input logic [31:0] lvl,
                                     input logic [31:0] csize);
    logic [32:0] hi;
    begin
      hi = {1'b0, lvl} + {1'b0, csize};
      return (p >= lvl) && ({1'b0, p} <= hi);
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/pda_in_if.sv
`default_nettype none
interface pda_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [30:0] particle_number;
  logic [9:0]  file_number;

  modport source (output valid, pos_x, pos_y, pos_z, particle_number, file_number,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, particle_number, file_number,
                output ready);
endinterface
`default_nettype wire

>>> rtl/pda_out_if.sv
`default_nettype none
interface pda_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  domain_index;
  logic        matched;
  logic        interior;
  logic [31:0] record_number;
  logic [30:0] echo_particle;
  logic [9:0]  echo_file;
  logic        last;

  modport source (output valid, domain_index, matched, interior, record_number,
                  echo_particle, echo_file, last, input ready);
  modport sink (input valid, domain_index, matched, interior, record_number,
                echo_particle, echo_file, last, output ready);
  modport mon (input valid, ready, domain_index, matched, interior, record_number,
               echo_particle, echo_file, last);
endinterface
`default_nettype wire

>>> rtl/pda_front.sv
`default_nettype none
module pda_front #(
  parameter int unsigned GRID_PER_AXIS = pda_pkg::GRID_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [31:0]     cfg_data,
  pda_in_if.sink               in_ch,
  output pda_pkg::geom_t       geom,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output pda_pkg::task_t       q_data
);

  // floor(box / grid) as a multiply by a rounded-up reciprocal
  localparam int unsigned GSH    = 32 + $clog2(GRID_PER_AXIS);
  localparam logic [32:0] GRECIP = 33'(((65'd1 << GSH) + 65'(GRID_PER_AXIS) - 65'd1)
                                       / 65'(GRID_PER_AXIS));
  localparam logic [3:0]  GMOD   = 4'(GRID_PER_AXIS);

  pda_pkg::front_state_t state, state_next;
  logic [31:0] box, box_next, dom_size, dom_size_next, ov, ov_next;
  logic [64:0] size_prod;
  logic [63:0] halo_prod;
  logic [4:0]  cnt, cnt_next;
  logic [31:0] px, px_next, py, py_next, pz, pz_next;
  logic [31:0] sh [3];
  logic [31:0] sh_next [3];
  logic [31:0] rem [3];
  logic [31:0] rem_next [3];
  logic [2:0]  qm [3];
  logic [2:0]  qm_next [3];
  logic [31:0] step_rem [3];
  logic [2:0]  step_qm [3];
  logic        ge [3];
  logic [30:0] part, part_next;
  logic [9:0]  file, file_next;
  logic [32:0] shifted [3];
  logic [3:0]  t [3];

  // one restoring division bit per lane, with the quotient kept modulo the grid
  always_comb begin
    size_prod = {32'd0, box} * {32'd0, GRECIP};
    halo_prod = {32'd0, dom_size} * {32'd0, pda_pkg::HALO_RECIP};
    for (int a = 0; a < 3; a++) begin
      shifted[a]  = {rem[a], sh[a][31]};
      ge[a]       = shifted[a] >= {1'b0, dom_size};
      step_rem[a] = ge[a] ? 32'(shifted[a] - {1'b0, dom_size}) : shifted[a][31:0];
      t[a]        = {qm[a], ge[a]};
      step_qm[a]  = (t[a] >= GMOD) ? 3'(t[a] - GMOD) : t[a][2:0];
    end
  end

  always_comb begin
    state_next    = state;
    box_next      = box;
    dom_size_next = dom_size;
    ov_next       = ov;
    cnt_next      = cnt;
    px_next       = px;
    py_next       = py;
    pz_next       = pz;
    part_next     = part;
    file_next     = file;
    sh_next       = sh;
    rem_next      = rem;
    qm_next       = qm;
    in_ch.ready   = 1'b0;
    q_valid       = 1'b0;
    case (state)
      pda_pkg::F_CELL: begin
        dom_size_next = 32'(size_prod >> GSH);
        state_next    = pda_pkg::F_OV;
      end
      pda_pkg::F_OV: begin
        ov_next    = 32'(halo_prod >> pda_pkg::HALO_SHIFT);
        state_next = pda_pkg::F_IDLE;
      end
      pda_pkg::F_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          px_next    = in_ch.pos_x;
          py_next    = in_ch.pos_y;
          pz_next    = in_ch.pos_z;
          sh_next[0] = in_ch.pos_x;
          sh_next[1] = in_ch.pos_y;
          sh_next[2] = in_ch.pos_z;
          for (int a = 0; a < 3; a++) begin
            rem_next[a] = '0;
            qm_next[a]  = '0;
          end
          part_next  = in_ch.particle_number;
          file_next  = in_ch.file_number;
          cnt_next   = 5'd0;
          state_next = pda_pkg::F_HOME;
        end
      end
      pda_pkg::F_HOME: begin
        for (int a = 0; a < 3; a++) begin
          rem_next[a] = step_rem[a];
          qm_next[a]  = step_qm[a];
          sh_next[a]  = {sh[a][30:0], 1'b0};
        end
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) state_next = pda_pkg::F_PUSH;
      end
      pda_pkg::F_PUSH: begin
        q_valid = 1'b1;
        if (q_ready) state_next = pda_pkg::F_IDLE;
      end
      default: state_next = pda_pkg::F_CELL;
    endcase
    if (cfg_we) begin
      box_next   = cfg_data;
      state_next = pda_pkg::F_CELL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pda_pkg::F_CELL;
      box   <= pda_pkg::BOX_RESET;
    end else begin
      state <= state_next;
      box   <= box_next;
    end
  end

  always_ff @(posedge clk) begin
    dom_size <= dom_size_next;
    ov       <= ov_next;
    cnt      <= cnt_next;
    px       <= px_next;
    py       <= py_next;
    pz       <= pz_next;
    part     <= part_next;
    file     <= file_next;
    sh       <= sh_next;
    rem      <= rem_next;
    qm       <= qm_next;
  end

  assign geom.box      = box;
  assign geom.dom_size = dom_size;
  assign geom.ov       = ov;

  // zero cell puts every point in the first domain of each axis
  assign q_data.px   = px;
  assign q_data.py   = py;
  assign q_data.pz   = pz;
  assign q_data.hx   = (dom_size == '0) ? 3'd0 : qm[0];
  assign q_data.hy   = (dom_size == '0) ? 3'd0 : qm[1];
  assign q_data.hz   = (dom_size == '0) ? 3'd0 : qm[2];
  assign q_data.part = part;
  assign q_data.file = file;

endmodule
`default_nettype wire

>>> rtl/pda_queue.sv
`default_nettype none
module pda_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pda_pkg::task_t in_data,
  output logic                out_valid,
  input  wire logic           out_pop,
  output pda_pkg::task_t      out_data
);

  pda_pkg::task_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign in_ready  = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_data  = mem[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end

endmodule
`default_nettype wire

>>> rtl/pda_back.sv
`default_nettype none
module pda_back #(
  parameter int unsigned GRID_PER_AXIS = pda_pkg::GRID_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pda_pkg::geom_t geom,
  input  wire logic           t_valid,
  input  wire pda_pkg::task_t t_data,
  output logic                t_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pda_pkg::rec_t       out_rec
);

  localparam logic [4:0]  G5  = 5'(GRID_PER_AXIS);
  localparam logic [11:0] G12 = 12'(GRID_PER_AXIS);
  localparam logic [11:0] GG  = 12'(GRID_PER_AXIS * GRID_PER_AXIS);

  pda_pkg::back_state_t state, state_next;
  logic [1:0]  dx, dy, dz, dx_next, dy_next, dz_next;
  logic [3:0]  n, n_next;
  logic [31:0] rec_cnt, rec_cnt_next;
  logic        pend_valid, pend_valid_next;
  pda_pkg::rec_t pend, pend_next, out_next;
  logic        out_valid_next;
  logic        can_push, skip, hit, last_combo;
  logic [2:0]  ix, iy, iz;
  logic [31:0] lx, ly, lz;
  logic [11:0] jw;

  function automatic logic [2:0] wrap(input logic [2:0] h, input logic [1:0] d);
    logic [4:0] s;
    begin
      s = 5'(h) + 5'(d) + G5 - 5'd1;
      if (s >= G5) s = s - G5;
      if (s >= G5) s = s - G5;
      return s[2:0];
    end
  endfunction

  always_comb begin
    ix = wrap(t_data.hx, dx);
    iy = wrap(t_data.hy, dy);
    iz = wrap(t_data.hz, dz);
    lx = 32'(ix * geom.dom_size);
    ly = 32'(iy * geom.dom_size);
    lz = 32'(iz * geom.dom_size);
    jw = 12'(ix) + 12'(iy) * G12 + 12'(iz) * GG;
    // a repeated neighbour is the one whose offset reaches past the grid
    skip = (5'(dx) >= G5) || (5'(dy) >= G5) || (5'(dz) >= G5);
    hit  = !skip &&
           pda_pkg::axis_holds(t_data.px, lx, geom.dom_size, geom.ov, geom.box) &&
           pda_pkg::axis_holds(t_data.py, ly, geom.dom_size, geom.ov, geom.box) &&
           pda_pkg::axis_holds(t_data.pz, lz, geom.dom_size, geom.ov, geom.box);
    last_combo = (dx == 2'd2) && (dy == 2'd2) && (dz == 2'd2);
  end

  assign can_push = !out_valid || out_ready;

  always_comb begin
    state_next      = state;
    dx_next         = dx;
    dy_next         = dy;
    dz_next         = dz;
    n_next          = n;
    rec_cnt_next    = rec_cnt;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    out_valid_next  = out_valid && !out_ready;
    out_next        = out_rec;
    t_pop           = 1'b0;
    case (state)
      pda_pkg::B_RUN: begin
        if (t_valid && can_push) begin
          if (hit) begin
            if (pend_valid) begin
              out_next       = pend;
              out_valid_next = 1'b1;
            end
            pend_next.domain_index  = jw[5:0];
            pend_next.matched       = 1'b1;
            pend_next.interior      =
              pda_pkg::axis_core(t_data.px, lx, geom.dom_size) &&
              pda_pkg::axis_core(t_data.py, ly, geom.dom_size) &&
              pda_pkg::axis_core(t_data.pz, lz, geom.dom_size);
            pend_next.record_number = rec_cnt;
            pend_next.echo_particle = t_data.part;
            pend_next.echo_file     = t_data.file;
            pend_next.last          = 1'b0;
            pend_valid_next         = 1'b1;
            if (rec_cnt != '1) rec_cnt_next = rec_cnt + 32'd1;
            n_next = n + 4'd1;
          end
          dz_next = (dz == 2'd2) ? 2'd0 : dz + 2'd1;
          if (dz == 2'd2) begin
            dy_next = (dy == 2'd2) ? 2'd0 : dy + 2'd1;
            if (dy == 2'd2) dx_next = dx + 2'd1;
          end
          if (last_combo || (hit && n == 4'(pda_pkg::MAX_REC - 1)))
            state_next = pda_pkg::B_DONE;
        end
      end
      pda_pkg::B_DONE: begin
        if (can_push) begin
          out_valid_next = 1'b1;
          if (pend_valid) begin
            out_next      = pend;
            out_next.last = 1'b1;
          end else begin
            out_next.domain_index  = '0;
            out_next.matched       = 1'b0;
            out_next.interior      = 1'b0;
            out_next.record_number = rec_cnt;
            out_next.echo_particle = t_data.part;
            out_next.echo_file     = t_data.file;
            out_next.last          = 1'b1;
          end
          t_pop           = 1'b1;
          pend_valid_next = 1'b0;
          n_next          = 4'd0;
          dx_next         = 2'd0;
          dy_next         = 2'd0;
          dz_next         = 2'd0;
          state_next      = pda_pkg::B_RUN;
        end
      end
      default: state_next = pda_pkg::B_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pda_pkg::B_RUN;
      dx         <= 2'd0;
      dy         <= 2'd0;
      dz         <= 2'd0;
      n          <= 4'd0;
      rec_cnt    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      dx         <= dx_next;
      dy         <= dy_next;
      dz         <= dz_next;
      n          <= n_next;
      rec_cnt    <= rec_cnt_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend    <= pend_next;
    out_rec <= out_next;
  end

endmodule
`default_nettype wire

>>> rtl/periodic_domain_assigner.sv
// Periodic domain assigner: each accepted particle gives one to eight membership
// beats, one per matching domain of its 27 wrapped neighbours, or a single beat with
// matched clear. After reset and after every box_size write the block derives the
// cell size and halo (one reciprocal multiplication each) before it takes a particle.
// Each particle then passes through the bit-serial home-cell division in the front
// end and through the back end, which walks the neighbours one per cycle while the
// output is not stalled; a two-entry queue lets the two overlap, so the front end can
// take a new particle while the back end is still walking the last one's neighbours.
`default_nettype none
module periodic_domain_assigner #(
  parameter int unsigned GRID_PER_AXIS = pda_pkg::GRID_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  pda_in_if.sink           in_ch,
  pda_out_if.source        out_ch
);

  pda_pkg::geom_t geom;
  pda_pkg::task_t f_data, b_data;
  pda_pkg::rec_t  rec;
  logic f_valid, f_ready, b_valid, b_pop;

  pda_front #(.GRID_PER_AXIS(GRID_PER_AXIS)) u_front (
    .clk, .rst, .cfg_we, .cfg_data, .in_ch, .geom,
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  pda_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(b_valid), .out_pop(b_pop), .out_data(b_data)
  );

  pda_back #(.GRID_PER_AXIS(GRID_PER_AXIS)) u_back (
    .clk, .rst, .geom,
    .t_valid(b_valid), .t_data(b_data), .t_pop(b_pop),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_rec(rec)
  );

  assign out_ch.domain_index  = rec.domain_index;
  assign out_ch.matched       = rec.matched;
  assign out_ch.interior      = rec.interior;
  assign out_ch.record_number = rec.record_number;
  assign out_ch.echo_particle = rec.echo_particle;
  assign out_ch.echo_file     = rec.echo_file;
  assign out_ch.last          = rec.last;

endmodule
`default_nettype wire

>>> rtl/pda_checker.sv
`default_nettype none
module pda_sva (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        valid,
  input wire logic        ready,
  input wire logic [5:0]  domain_index,
  input wire logic        matched,
  input wire logic        interior,
  input wire logic [31:0] record_number,
  input wire logic        last
);

  // a stalled beat keeps its record number
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(record_number))
    else $error("stalled beat changed");

  // a no-match beat is alone and carries no domain
  a_nomatch: assert property (@(posedge clk) disable iff (rst)
    valid && !matched |-> last && domain_index == 6'd0 && !interior)
    else $error("bad no-match beat");

  a_interior: assert property (@(posedge clk) disable iff (rst)
    valid && interior |-> matched)
    else $error("interior without match");

  // after a beat that is not the last of its particle, the next beat is a match
  a_seq: assert property (@(posedge clk) disable iff (rst)
    valid && ready && !last |=> (valid && ready)[->1] ##0 matched)
    else $error("sequence");

endmodule

bind periodic_domain_assigner pda_sva u_pda_sva (
  .clk(clk), .rst(rst), .valid(out_ch.valid), .ready(out_ch.ready),
  .domain_index(out_ch.domain_index), .matched(out_ch.matched),
  .interior(out_ch.interior), .record_number(out_ch.record_number),
  .last(out_ch.last)
);
`default_nettype wire
